/* hdl/bsc_pkg.sv */
// Package for the board symmetry canonicalizer.
// Holds the request structs, mode codes, sizing constants and the D4 square map.
// No dependencies.
`default_nettype none

package bsc_pkg;

    // Fixed field widths.
    localparam int MASK_W  = 64;
    localparam int COUNT_W = 5;
    localparam int MODE_W  = 2;
    localparam int SQ_W    = 6;

    // Default board side and the scan sizes.
    localparam int DEFAULT_SIDE   = 8;
    localparam int SHIFTS         = 8;
    localparam int SHIFT_W        = $clog2(SHIFTS);
    localparam int D4_SIZE        = 8;
    localparam int DIH_W          = $clog2(D4_SIZE);

    // Symmetry mode codes; the unused code behaves as identity.
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIHEDRAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TORUS    = 2'd2;

    // D4 transform codes.
    localparam int XF_IDENT   = 0;
    localparam int XF_ROT90   = 1;
    localparam int XF_ROT180  = 2;
    localparam int XF_ROT270  = 3;
    localparam int XF_FLIP_C  = 4;
    localparam int XF_ANTI    = 5;
    localparam int XF_FLIP_R  = 6;
    localparam int XF_DIAG    = 7;

    typedef struct packed {
        logic [MASK_W-1:0]  blue_bits;
        logic [MASK_W-1:0]  red_bits;
        logic [COUNT_W-1:0] blue_count;
        logic [COUNT_W-1:0] red_count;
        logic               red_to_move;
    } in_t;

    typedef struct packed {
        logic [MASK_W-1:0]  mover_canon_bits;
        logic [MASK_W-1:0]  other_canon_bits;
        logic [COUNT_W-1:0] mover_count;
        logic [COUNT_W-1:0] other_count;
    } out_t;

    // Source square that lands on (nr, nc) under transform xf. This is the
    // inverse of the forward map; only the two quarter turns swap roles.
    function automatic int src_square(int xf, int nr, int nc, int side);
        int last;
        int r;
        int c;
        last = side - 1;
        case (xf)
            XF_ROT90:  begin r = last - nc; c = nr;        end
            XF_ROT180: begin r = last - nr; c = last - nc; end
            XF_ROT270: begin r = nc;        c = last - nr; end
            XF_FLIP_C: begin r = nr;        c = last - nc; end
            XF_ANTI:   begin r = last - nc; c = last - nr; end
            XF_FLIP_R: begin r = last - nr; c = nc;        end
            XF_DIAG:   begin r = nc;        c = nr;        end
            default:   begin r = nr;        c = nc;        end
        endcase
        return r * side + c;
    endfunction

endpackage

`default_nettype wire

/* hdl/bsc_xform.sv */
// Shared permutation unit of the board symmetry canonicalizer.
// Gives the selected D4 image of the stored pair and one-step row and column wraps.
// Depends on bsc_pkg.
`default_nettype none

module bsc_xform #(
    parameter int SIDE = bsc_pkg::DEFAULT_SIDE
) (
    input  wire logic [bsc_pkg::DIH_W-1:0]  dih_sel,
    input  wire logic [bsc_pkg::MASK_W-1:0] orig_a,
    input  wire logic [bsc_pkg::MASK_W-1:0] orig_b,
    input  wire logic [bsc_pkg::MASK_W-1:0] cur_a,
    input  wire logic [bsc_pkg::MASK_W-1:0] cur_b,
    input  wire logic [bsc_pkg::MASK_W-1:0] row_a,
    input  wire logic [bsc_pkg::MASK_W-1:0] row_b,
    output logic      [bsc_pkg::MASK_W-1:0] dih_a,
    output logic      [bsc_pkg::MASK_W-1:0] dih_b,
    output logic      [bsc_pkg::MASK_W-1:0] col_a,
    output logic      [bsc_pkg::MASK_W-1:0] col_b,
    output logic      [bsc_pkg::MASK_W-1:0] rowrot_a,
    output logic      [bsc_pkg::MASK_W-1:0] rowrot_b
);
    import bsc_pkg::*;

    // D4 image: each board square picks its source through an 8-way mux.
    always_comb
    begin
        dih_a = '0;
        dih_b = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                dih_a[SQ_W'(r * SIDE + c)] =
                    orig_a[SQ_W'(src_square(int'(dih_sel), r, c, SIDE))];
                dih_b[SQ_W'(r * SIDE + c)] =
                    orig_b[SQ_W'(src_square(int'(dih_sel), r, c, SIDE))];
            end
        end
    end

    // Column wrap by one: square (r, c) moves to (r, c+1 mod SIDE).
    always_comb
    begin
        col_a = '0;
        col_b = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                col_a[SQ_W'(r * SIDE + (c + 1) % SIDE)] = cur_a[SQ_W'(r * SIDE + c)];
                col_b[SQ_W'(r * SIDE + (c + 1) % SIDE)] = cur_b[SQ_W'(r * SIDE + c)];
            end
        end
    end

    // Row wrap by one: square (r, c) moves to (r+1 mod SIDE, c).
    always_comb
    begin
        rowrot_a = '0;
        rowrot_b = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                rowrot_a[SQ_W'(((r + 1) % SIDE) * SIDE + c)] = row_a[SQ_W'(r * SIDE + c)];
                rowrot_b[SQ_W'(((r + 1) % SIDE) * SIDE + c)] = row_b[SQ_W'(r * SIDE + c)];
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/board_symmetry_canonicalizer_top.sv */
// Top level of the board symmetry canonicalizer.
// Holds the scan sequencer, the running minimum and the output register.
// Depends on bsc_pkg and bsc_xform.
//
// Usage:
// - A request on src (src_valid/src_ready, payload src_data) carries two
//   occupancy masks, two reserve counts and the side-to-move flag. The
//   result request leaves on dst (dst_valid/dst_ready, payload dst_data).
// - cfg_we writes cfg_wdata into the symmetry mode register (reset value:
//   identity only). Write it only while no request is in flight.
// - Each candidate is produced by the shared permutation unit and compared
//   with the running minimum, so the scan covers the identity alone in
//   identity mode, the 8 D4 images in dihedral mode and 8 x 8 x 8 = 512
//   candidates in torus mode. The result then loads the output register,
//   which raises dst_valid, and the sequencer returns to idle.
// - src_ready is high only while the sequencer is idle; one request is
//   processed at a time.
// - If the receiver stalls, the finished result waits in the sequencer
//   until the output register frees up; dst_data holds steady meanwhile.
// - Reset clears the sequencer, dst_valid and the mode register.
`default_nettype none

module board_symmetry_canonicalizer_top #(
    parameter int SIDE = bsc_pkg::DEFAULT_SIDE
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       src_valid,
    output logic                            src_ready,
    input  wire bsc_pkg::in_t               src_data,
    output logic                            dst_valid,
    input  wire logic                       dst_ready,
    output bsc_pkg::out_t                   dst_data,
    input  wire logic                       cfg_we,
    input  wire logic [bsc_pkg::MODE_W-1:0] cfg_wdata
);
    import bsc_pkg::*;

    localparam int NUM_SQ = SIDE * SIDE;
    localparam logic [MASK_W-1:0] BoardMask =
        (NUM_SQ >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << NUM_SQ) - MASK_W'(1));

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [DIH_W-1:0]   t_reg, t_next;
    logic [SHIFT_W-1:0] rs_reg, rs_next;
    logic [SHIFT_W-1:0] cs_reg, cs_next;
    logic [MASK_W-1:0]  orig_a_reg, orig_b_reg;
    logic [MASK_W-1:0]  cur_a_reg, cur_a_next, cur_b_reg, cur_b_next;
    logic [MASK_W-1:0]  row_a_reg, row_a_next, row_b_reg, row_b_next;
    logic [MASK_W-1:0]  best_a_reg, best_a_next, best_b_reg, best_b_next;
    logic [COUNT_W-1:0] mover_cnt_reg, other_cnt_reg;
    logic               dst_valid_reg;
    out_t               dst_data_reg;

    logic [MASK_W-1:0]  dih_a, dih_b, col_a, col_b, rowrot_a, rowrot_b;
    logic [MASK_W-1:0]  mover_in, other_in;
    logic [DIH_W-1:0]   dih_sel;
    logic               accept, load_out, better;
    logic               last_cs, last_rs, last_t, torus, dihedral;

    assign src_ready = (state_reg == ST_IDLE);
    assign accept    = src_valid && src_ready;
    assign load_out  = (state_reg == ST_DONE) && (!dst_valid_reg || dst_ready);
    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    // Swap so the player to move comes first; drop bits off the board.
    assign mover_in = (src_data.red_to_move ? src_data.red_bits : src_data.blue_bits)
                      & BoardMask;
    assign other_in = (src_data.red_to_move ? src_data.blue_bits : src_data.red_bits)
                      & BoardMask;

    // Shared permutation unit; the D4 image is prepared for the next transform.
    assign dih_sel = t_reg + DIH_W'(1);

    bsc_xform #(
        .SIDE (SIDE)
    ) u_xform (
        .dih_sel  (dih_sel),
        .orig_a   (orig_a_reg),
        .orig_b   (orig_b_reg),
        .cur_a    (cur_a_reg),
        .cur_b    (cur_b_reg),
        .row_a    (row_a_reg),
        .row_b    (row_b_reg),
        .dih_a    (dih_a),
        .dih_b    (dih_b),
        .col_a    (col_a),
        .col_b    (col_b),
        .rowrot_a (rowrot_a),
        .rowrot_b (rowrot_b)
    );

    // Scan limits from the mode; the unused code falls back to identity.
    assign torus    = (mode_reg == MODE_TORUS);
    assign dihedral = (mode_reg == MODE_DIHEDRAL) || torus;
    assign last_cs  = !torus || (cs_reg == SHIFT_W'(SHIFTS - 1));
    assign last_rs  = !torus || (rs_reg == SHIFT_W'(SHIFTS - 1));
    assign last_t   = !dihedral || (t_reg == DIH_W'(D4_SIZE - 1));

    // Candidate comparison: first mask, then second mask.
    assign better = (cur_a_reg < best_a_reg) ||
                    ((cur_a_reg == best_a_reg) && (cur_b_reg < best_b_reg));

    // Sequencer: walks column shifts, then row shifts, then D4 transforms.
    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        rs_next     = rs_reg;
        cs_next     = cs_reg;
        cur_a_next  = cur_a_reg;
        cur_b_next  = cur_b_reg;
        row_a_next  = row_a_reg;
        row_b_next  = row_b_reg;
        best_a_next = best_a_reg;
        best_b_next = best_b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_SCAN;
                    t_next      = '0;
                    rs_next     = '0;
                    cs_next     = '0;
                    cur_a_next  = mover_in;
                    cur_b_next  = other_in;
                    row_a_next  = mover_in;
                    row_b_next  = other_in;
                    best_a_next = mover_in;
                    best_b_next = other_in;
                end
            end
            ST_SCAN:
            begin
                if (better)
                begin
                    best_a_next = cur_a_reg;
                    best_b_next = cur_b_reg;
                end
                if (!last_cs)
                begin
                    cs_next    = cs_reg + SHIFT_W'(1);
                    cur_a_next = col_a;
                    cur_b_next = col_b;
                end
                else if (!last_rs)
                begin
                    cs_next    = '0;
                    rs_next    = rs_reg + SHIFT_W'(1);
                    cur_a_next = rowrot_a;
                    cur_b_next = rowrot_b;
                    row_a_next = rowrot_a;
                    row_b_next = rowrot_b;
                end
                else if (!last_t)
                begin
                    cs_next    = '0;
                    rs_next    = '0;
                    t_next     = dih_sel;
                    cur_a_next = dih_a;
                    cur_b_next = dih_b;
                    row_a_next = dih_a;
                    row_b_next = dih_b;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDENTITY;
            dst_valid_reg <= 1'b0;
            t_reg         <= '0;
            rs_reg        <= '0;
            cs_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            rs_reg    <= rs_next;
            cs_reg    <= cs_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (dst_ready)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_a_reg  <= cur_a_next;
        cur_b_reg  <= cur_b_next;
        row_a_reg  <= row_a_next;
        row_b_reg  <= row_b_next;
        best_a_reg <= best_a_next;
        best_b_reg <= best_b_next;
        if (accept)
        begin
            orig_a_reg    <= mover_in;
            orig_b_reg    <= other_in;
            mover_cnt_reg <= src_data.red_to_move ? src_data.red_count : src_data.blue_count;
            other_cnt_reg <= src_data.red_to_move ? src_data.blue_count : src_data.red_count;
        end
        if (load_out)
        begin
            dst_data_reg.mover_canon_bits <= best_a_reg;
            dst_data_reg.other_canon_bits <= best_b_reg;
            dst_data_reg.mover_count      <= mover_cnt_reg;
            dst_data_reg.other_count      <= other_cnt_reg;
        end
    end

`ifndef SYNTHESIS
    // A result appears only after the sequencer has finished a scan.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished scan");

    // The running minimum never grows during a scan.
    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && $past(state_reg == ST_SCAN)
        |-> (best_a_reg <= $past(best_a_reg)))
        else $error("running minimum increased");

    // Shift counters stay at zero outside torus mode.
    a_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && !torus |-> (cs_reg == '0) && (rs_reg == '0))
        else $error("shift counters moved outside torus mode");

    // In identity mode the result is the swapped input.
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !dihedral
        |-> (best_a_reg == orig_a_reg) && (best_b_reg == orig_b_reg))
        else $error("identity mode changed the board");
`endif

endmodule

`default_nettype wire
